@@ rtl/btk_pkg.sv @@
`timescale 1ns / 1ps

package btk_pkg;

  // Default sizing of the top level.
  localparam int DefMaxBeams = 16;
  localparam int DefMaxVocab = 65536;

  // Configuration port.
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgVocabIdx = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgBeamIdx  = 8'd1;

  localparam int VocabW = 17;
  localparam int BeamCntW = 5;
  localparam int KeepW = 6;

  localparam logic [VocabW-1:0]   VocabReset = 17'd65536;
  localparam logic [BeamCntW-1:0] BeamReset  = 5'd4;

  // Field widths.
  localparam int ScoreW = 32;
  localparam int BeamIdxW = 4;
  localparam int TokenW = 16;

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;

  typedef logic signed [ScoreW-1:0] score_t;

  // One classified word, as the front hands it to the back.
  typedef struct packed {
    score_t                sum;
    logic [BeamIdxW-1:0]   beam;
    logic [TokenW-1:0]     token;
    logic                  last;
    logic [KeepW-1:0]      keep;
  } btk_item_t;

endpackage

@@ rtl/btk_if.sv @@
`timescale 1ns / 1ps

interface btk_in_if;
  import btk_pkg::*;
  logic   valid;
  logic   ready;
  score_t token_score;
  score_t beam_score;
  logic   row_last;
  modport source (output valid, output token_score, output beam_score, output row_last,
                  input ready);
  modport sink   (input valid, input token_score, input beam_score, input row_last,
                  output ready);
endinterface

interface btk_out_if;
  import btk_pkg::*;
  logic                valid;
  logic                ready;
  logic [BeamIdxW-1:0] beam_index;
  logic [TokenW-1:0]   token_id;
  score_t              total_score;
  logic                emit_last;
  modport source (output valid, output beam_index, output token_id, output total_score,
                  output emit_last, input ready);
  modport sink   (input valid, input beam_index, input token_id, input total_score,
                  input emit_last, output ready);
endinterface

interface btk_cfg_if;
  import btk_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/beam_topk_selection.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Word                                          Accepted when
// in_i     in   token_score, beam_score, row_last             in_i.valid && in_i.ready
// out_o    out  beam_index, token_id, total_score, emit_last  out_o.valid && out_o.ready
// cfg_i    in   index, data (0: vocab_count, 1: beam_count)   cfg_i.valid && cfg_i.ready
//
// Flow: one input word per cycle while the back absorbs; the insertion chain
// places each sum as the back takes it. A row end sends the back into emission of
// every kept entry, best first (at most twice beam_count clamped to 2..MAX_BEAMS).
// During that burst the two-word queue keeps taking input until it fills.
// Reset clears counters, fill count and the queue; the kept store is unset.
// Either side may stall at will; cfg_i is always ready.

module beam_topk_selection #(
  parameter int MAX_BEAMS = btk_pkg::DefMaxBeams,
  parameter int MAX_VOCAB = btk_pkg::DefMaxVocab
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btk_in_if.sink     in_i,
  btk_out_if.source  out_o,
  btk_cfg_if.sink    cfg_i
);
  import btk_pkg::*;

  logic [VocabW-1:0]   vocab_q;
  logic [BeamCntW-1:0] beams_q;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  btk_item_t push_item, pop_item;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q <= VocabReset;
      beams_q <= BeamReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CfgVocabIdx: vocab_q <= cfg_i.data[VocabW-1:0];
        CfgBeamIdx:  beams_q <= cfg_i.data[BeamCntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: saturating add, position counters, keep count.
  btk_front #(
    .MAX_BEAMS (MAX_BEAMS),
    .MAX_VOCAB (MAX_VOCAB)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .vocab_count_i (vocab_q),
    .beam_count_i  (beams_q),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  // Queue decouples input from the emission burst.
  btk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: sorted insertion chain and best-first emission.
  btk_back #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

@@ rtl/btk_front.sv @@
`timescale 1ns / 1ps

module btk_front #(
  parameter int MAX_BEAMS = btk_pkg::DefMaxBeams,
  parameter int MAX_VOCAB = btk_pkg::DefMaxVocab
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  btk_in_if.sink                       in_i,
  input  logic [btk_pkg::VocabW-1:0]   vocab_count_i,
  input  logic [btk_pkg::BeamCntW-1:0] beam_count_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output btk_pkg::btk_item_t           push_item_o
);
  import btk_pkg::*;

  localparam int TokCW  = ($clog2(MAX_VOCAB) > TokenW) ? $clog2(MAX_VOCAB) : TokenW;
  localparam int BeamCW = ($clog2(MAX_BEAMS) > BeamIdxW) ? $clog2(MAX_BEAMS) : BeamIdxW;
  localparam int BeamCW1 = BeamCW + 1;
  localparam int VEffW  = ($clog2(MAX_VOCAB + 1) > VocabW) ? $clog2(MAX_VOCAB + 1) : VocabW;
  localparam int CmpW   = (TokCW + 1 > VEffW) ? TokCW + 1 : VEffW;
  localparam int BClW   = BeamCntW + 1;

  logic [TokCW-1:0]  tok_q, tok_d;
  logic [BeamCW-1:0] beam_q, beam_d;

  logic [VEffW-1:0]   vocab_ext, vocab_eff;
  logic [CmpW-1:0]    tok_inc;
  logic               tok_wrap;
  logic [BeamCW1-1:0] beam_inc;
  logic               beam_wrap;
  logic [BClW-1:0]    beams_ext, beams_eff;
  logic [BClW:0]      keep_wide;
  logic signed [ScoreW:0] sum_wide;
  score_t             sum_sat;
  logic               accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // Saturating add of token and beam score.
  always_comb begin
    sum_wide = {in_i.token_score[ScoreW-1], in_i.token_score}
             + {in_i.beam_score[ScoreW-1], in_i.beam_score};
    if (sum_wide[ScoreW] != sum_wide[ScoreW-1]) begin
      sum_sat = sum_wide[ScoreW] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ScoreW-1:0];
    end
  end

  // Clamp the registers to their usable ranges.
  always_comb begin
    vocab_ext = VEffW'(vocab_count_i);
    if (vocab_ext == '0) begin
      vocab_eff = VEffW'(1);
    end else if (vocab_ext > VEffW'(MAX_VOCAB)) begin
      vocab_eff = VEffW'(MAX_VOCAB);
    end else begin
      vocab_eff = vocab_ext;
    end

    beams_ext = BClW'(beam_count_i);
    if (beams_ext < BClW'(2)) begin
      beams_eff = BClW'(2);
    end else if (beams_ext > BClW'(MAX_BEAMS)) begin
      beams_eff = BClW'(MAX_BEAMS);
    end else begin
      beams_eff = beams_ext;
    end
    keep_wide = {beams_eff, 1'b0};
  end

  // Position counters stand in for divide and modulo by the vocabulary size.
  always_comb begin
    tok_inc   = CmpW'(tok_q) + CmpW'(1);
    tok_wrap  = tok_inc >= CmpW'(vocab_eff);
    beam_inc  = BeamCW1'(beam_q) + BeamCW1'(1);
    beam_wrap = beam_inc >= BeamCW1'(MAX_BEAMS);
    if (in_i.row_last) begin
      tok_d  = '0;
      beam_d = '0;
    end else if (tok_wrap) begin
      tok_d  = '0;
      beam_d = beam_wrap ? '0 : beam_inc[BeamCW-1:0];
    end else begin
      tok_d  = tok_inc[TokCW-1:0];
      beam_d = beam_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      beam_q <= '0;
    end else if (accept) begin
      tok_q  <= tok_d;
      beam_q <= beam_d;
    end
  end

  always_comb begin
    push_item_o.sum   = sum_sat;
    push_item_o.beam  = beam_q[BeamIdxW-1:0];
    push_item_o.token = tok_q[TokenW-1:0];
    push_item_o.last  = in_i.row_last;
    push_item_o.keep  = keep_wide[KeepW-1:0];
  end

endmodule

@@ rtl/btk_queue.sv @@
`timescale 1ns / 1ps

module btk_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  btk_pkg::btk_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output btk_pkg::btk_item_t pop_item_o
);
  import btk_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  btk_item_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    rd_d  = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_d;
      if (pop)  rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_item_i;
  end

endmodule

@@ rtl/btk_back.sv @@
`timescale 1ns / 1ps

module btk_back #(
  parameter int MAX_BEAMS = btk_pkg::DefMaxBeams
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  btk_pkg::btk_item_t pop_item_i,
  btk_out_if.source          out_o
);
  import btk_pkg::*;

  localparam int KeepDepth = 2 * MAX_BEAMS;

  typedef enum logic [1:0] {
    ST_ABSORB = 2'b01,
    ST_EMIT   = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  score_t              kept_score_q [KeepDepth];
  logic [BeamIdxW-1:0] kept_beam_q  [KeepDepth];
  logic [TokenW-1:0]   kept_tok_q   [KeepDepth];
  score_t              kept_score_d [KeepDepth];
  logic [BeamIdxW-1:0] kept_beam_d  [KeepDepth];
  logic [TokenW-1:0]   kept_tok_d   [KeepDepth];

  logic [KeepW-1:0]     fill_q, fill_d, fill_eff;
  logic [KeepW:0]       fill_inc;
  logic [KeepDepth-1:0] ge;
  logic                 take, give;

  assign pop_ready_o       = state_q == ST_ABSORB;
  assign take              = pop_valid_i && pop_ready_o;
  assign give              = out_o.valid && out_o.ready;
  assign out_o.valid       = state_q == ST_EMIT;
  assign out_o.beam_index  = kept_beam_q[0];
  assign out_o.token_id    = kept_tok_q[0];
  assign out_o.total_score = kept_score_q[0];
  assign out_o.emit_last   = fill_q == KeepW'(1);

  // Insertion chain: every entry compares against the new sum at once.
  always_comb begin
    fill_eff = (fill_q > pop_item_i.keep) ? pop_item_i.keep : fill_q;
    for (int i = 0; i < KeepDepth; i++) begin
      ge[i] = ((KeepW + 1)'(i) < {1'b0, fill_eff}) && (kept_score_q[i] >= pop_item_i.sum);
    end
    fill_inc = {1'b0, fill_eff} + (KeepW + 1)'(1);
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    for (int i = 0; i < KeepDepth; i++) begin
      kept_score_d[i] = kept_score_q[i];
      kept_beam_d[i]  = kept_beam_q[i];
      kept_tok_d[i]   = kept_tok_q[i];
    end
    case (state_q)
      ST_ABSORB: begin
        if (take) begin
          // Hold entries that rank ahead, drop the new word in, push the rest down.
          if (!ge[0]) begin
            kept_score_d[0] = pop_item_i.sum;
            kept_beam_d[0]  = pop_item_i.beam;
            kept_tok_d[0]   = pop_item_i.token;
          end
          for (int i = 1; i < KeepDepth; i++) begin
            if (!ge[i]) begin
              if (ge[i-1]) begin
                kept_score_d[i] = pop_item_i.sum;
                kept_beam_d[i]  = pop_item_i.beam;
                kept_tok_d[i]   = pop_item_i.token;
              end else begin
                kept_score_d[i] = kept_score_q[i-1];
                kept_beam_d[i]  = kept_beam_q[i-1];
                kept_tok_d[i]   = kept_tok_q[i-1];
              end
            end
          end
          fill_d = (fill_inc > {1'b0, pop_item_i.keep}) ? pop_item_i.keep
                                                         : fill_inc[KeepW-1:0];
          if (pop_item_i.last) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (give) begin
          // Advance the store toward the head, one entry per word.
          for (int i = 0; i < KeepDepth - 1; i++) begin
            kept_score_d[i] = kept_score_q[i+1];
            kept_beam_d[i]  = kept_beam_q[i+1];
            kept_tok_d[i]   = kept_tok_q[i+1];
          end
          fill_d = fill_q - KeepW'(1);
          if (fill_q == KeepW'(1)) state_d = ST_ABSORB;
        end
      end
      default: begin
        state_d = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ABSORB;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KeepDepth; i++) begin
      kept_score_q[i] <= kept_score_d[i];
      kept_beam_q[i]  <= kept_beam_d[i];
      kept_tok_q[i]   <= kept_tok_d[i];
    end
  end

endmodule
